### hdl/rttp_pkg.sv
`timescale 1ns / 1ps
// shared types, character codes and unit tables for the relative time parser
package rttp_pkg;

	localparam int UNIT_LETTERS_DEF = 7;
	localparam int DIR_LETTERS_DEF  = 3;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7a;

	localparam int         LIT_LEN_I = 17;
	localparam logic [4:0] LIT_LEN   = 5'd17;
	localparam logic [8*LIT_LEN_I-1:0] LIT_TEXT = "Undefined RelTime";

	localparam int         UNIT_COUNT = 7;
	localparam int         WORD_MAX   = 6;
	localparam logic [8*WORD_MAX-1:0] UNIT_WORD [UNIT_COUNT] = '{
		"second", "minute", "hour  ", "day   ", "week  ", "month ", "year  "
	};
	localparam logic [2:0] UNIT_LEN [UNIT_COUNT] = '{
		3'd6, 3'd6, 3'd4, 3'd3, 3'd4, 3'd5, 3'd4
	};

	localparam logic [8*3-1:0] DIR_AGO = "ago";

	typedef enum logic [1:0] {
		ST_VALID  = 2'd0,
		ST_SYNTAX = 2'd1,
		ST_UNDEF  = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	// finished parse handed from the parser to the scaling stage
	typedef struct packed {
		status_t     status;
		logic [2:0]  unit;
		logic [31:0] qty;
	} rttp_res_t;

	function automatic logic [7:0] lit_char(input logic [4:0] pos);
		if (pos < LIT_LEN)
			return LIT_TEXT[8*(LIT_LEN_I-1-int'(pos)) +: 8];
		else
			return CH_NUL;
	endfunction

	function automatic logic [31:0] unit_secs(input logic [2:0] u);
		case (u)
			3'd0: return 32'd1;
			3'd1: return 32'd60;
			3'd2: return 32'd3600;
			3'd3: return 32'd86400;
			3'd4: return 32'd604800;
			3'd5: return 32'd2592000;
			3'd6: return 32'd31536000;
			default: return 32'd1;
		endcase
	endfunction

	function automatic logic [31:0] unit_max(input logic [2:0] u);
		case (u)
			3'd0: return 32'd2144448000;
			3'd1: return 32'd35740800;
			3'd2: return 32'd595680;
			3'd3: return 32'd24820;
			3'd4: return 32'd3545;
			3'd5: return 32'd827;
			3'd6: return 32'd68;
			default: return 32'd0;
		endcase
	endfunction

endpackage

### hdl/rttp_parse.sv
`timescale 1ns / 1ps
// input register and per-character parser that builds one result per string
module rttp_parse #(
	parameter int UNIT_LETTERS = rttp_pkg::UNIT_LETTERS_DEF,
	parameter int DIR_LETTERS  = rttp_pkg::DIR_LETTERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          char_code,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                res_valid,
	output rttp_pkg::rttp_res_t res,
	input  logic                res_ready
);
	import rttp_pkg::*;

	localparam int BUF_LEN = (UNIT_LETTERS > DIR_LETTERS) ? UNIT_LETTERS : DIR_LETTERS;
	localparam int CNT_W   = $clog2(BUF_LEN + 1);
	localparam int IDX_W   = $clog2(BUF_LEN);
	localparam logic [CNT_W-1:0] UNIT_MAX_CNT = CNT_W'(UNIT_LETTERS);
	localparam logic [CNT_W-1:0] DIR_MAX_CNT  = CNT_W'(DIR_LETTERS);
	localparam logic [CNT_W-1:0] AGO_CNT      = CNT_W'(3);

	localparam logic [2:0] PH_SKIP = 3'd0;
	localparam logic [2:0] PH_LIT  = 3'd1;
	localparam logic [2:0] PH_AT   = 3'd2;
	localparam logic [2:0] PH_QTY  = 3'd3;
	localparam logic [2:0] PH_UNIT = 3'd4;
	localparam logic [2:0] PH_DIR  = 3'd5;
	localparam logic [2:0] PH_DONE = 3'd6;
	localparam logic [2:0] PH_ERR  = 3'd7;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             take_s1;
	logic             res_free;

	logic [2:0]       phase_q, phase_d;
	logic [31:0]      qty_q, qty_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [2:0]       unit_q, unit_d;
	logic             neg_q, neg_d;
	logic [4:0]       lit_pos_q, lit_pos_d;
	logic [7:0]       buf_q [BUF_LEN];
	logic             buf_we;

	logic             res_valid_s2;
	rttp_res_t        res_s2;
	rttp_res_t        res_d;

	logic [UNIT_COUNT-1:0] word_ok;
	logic             unit_hit;
	logic [2:0]       unit_hit_idx;
	logic             dir_ago;
	logic             is_lower;
	logic             is_digit;
	logic [35:0]      qty_sum;
	logic [31:0]      qty_next;
	status_t          term_status;
	logic [2:0]       term_unit;
	logic             term_neg;

	// a terminator needs room in the result register, other characters always pass
	assign res_free = !res_valid_s2 || res_ready;
	assign take_s1  = valid_s1 && ((char_s1 != CH_NUL) || res_free);
	assign in_ready = !valid_s1 || take_s1;

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	always_comb begin
		for (int k = 0; k < UNIT_COUNT; k++) begin
			word_ok[k] = (cnt_q >= CNT_W'(UNIT_LEN[k]));
			for (int i = 0; i < WORD_MAX; i++) begin
				if ((i < int'(UNIT_LEN[k])) &&
				    (buf_q[i] != UNIT_WORD[k][8*(WORD_MAX-1-i) +: 8]))
					word_ok[k] = 1'b0;
			end
		end
	end

	// first table word wins
	always_comb begin
		unit_hit     = 1'b0;
		unit_hit_idx = 3'd0;
		for (int k = UNIT_COUNT - 1; k >= 0; k--) begin
			if (word_ok[k]) begin
				unit_hit     = 1'b1;
				unit_hit_idx = 3'(k);
			end
		end
	end

	assign dir_ago = (cnt_q == AGO_CNT) && (buf_q[0] == DIR_AGO[23:16]) &&
	                 (buf_q[1] == DIR_AGO[15:8]) && (buf_q[2] == DIR_AGO[7:0]);

	assign is_lower = char_s1 inside {[CH_LOW_A:CH_LOW_Z]};
	assign is_digit = char_s1 inside {[CH_ZERO:CH_NINE]};

	// acc * 10 + digit, saturating at all ones
	assign qty_sum  = {1'b0, qty_q, 3'b000} + {3'b000, qty_q, 1'b0} + {32'd0, char_s1[3:0]};
	assign qty_next = (|qty_sum[35:32]) ? 32'hffff_ffff : qty_sum[31:0];

	always_comb begin
		phase_d   = phase_q;
		qty_d     = qty_q;
		cnt_d     = cnt_q;
		unit_d    = unit_q;
		neg_d     = neg_q;
		lit_pos_d = lit_pos_q;
		buf_we    = 1'b0;
		if (char_s1 == CH_NUL) begin
			phase_d   = PH_SKIP;
			qty_d     = '0;
			cnt_d     = '0;
			unit_d    = '0;
			neg_d     = 1'b0;
			lit_pos_d = '0;
		end else begin
			case (phase_q)
				PH_SKIP: begin
					if (char_s1 != CH_SPACE) begin
						if (char_s1 == lit_char(5'd0)) begin
							phase_d   = PH_LIT;
							lit_pos_d = 5'd1;
						end else if (char_s1 == CH_AT) begin
							phase_d = PH_AT;
						end else begin
							phase_d = PH_ERR;
						end
					end
				end
				PH_LIT: begin
					if (lit_pos_q < LIT_LEN && char_s1 == lit_char(lit_pos_q))
						lit_pos_d = lit_pos_q + 5'd1;
					else
						phase_d = PH_ERR;
				end
				PH_AT: begin
					if (char_s1 == CH_SPACE) begin
						qty_d   = '0;
						phase_d = PH_QTY;
					end else begin
						phase_d = PH_ERR;
					end
				end
				PH_QTY: begin
					if (is_digit) begin
						qty_d = qty_next;
					end else if (char_s1 == CH_SPACE) begin
						cnt_d   = '0;
						phase_d = PH_UNIT;
					end else begin
						phase_d = PH_ERR;
					end
				end
				PH_UNIT: begin
					if (is_lower && cnt_q < UNIT_MAX_CNT) begin
						buf_we = 1'b1;
						cnt_d  = cnt_q + 1'b1;
					end else if (char_s1 == CH_SPACE && unit_hit) begin
						cnt_d   = '0;
						unit_d  = unit_hit_idx;
						phase_d = PH_DIR;
					end else begin
						phase_d = PH_ERR;
					end
				end
				PH_DIR: begin
					if (is_lower && cnt_q < DIR_MAX_CNT) begin
						buf_we = 1'b1;
						cnt_d  = cnt_q + 1'b1;
					end else if (char_s1 == CH_SPACE) begin
						neg_d   = dir_ago;
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_ERR;
					end
				end
				default: ;
			endcase
		end
	end

	// outcome when the current character ends the string
	always_comb begin
		term_status = ST_SYNTAX;
		term_unit   = unit_q;
		term_neg    = neg_q;
		case (phase_q)
			PH_LIT: term_status = (lit_pos_q == LIT_LEN) ? ST_UNDEF : ST_SYNTAX;
			PH_UNIT: begin
				if (unit_hit) begin
					term_status = ST_VALID;
					term_unit   = unit_hit_idx;
					term_neg    = 1'b0;
				end
			end
			PH_DIR: begin
				term_status = ST_VALID;
				term_neg    = dir_ago;
			end
			PH_DONE: term_status = ST_VALID;
			default: ;
		endcase
		res_d.status = term_status;
		if (term_status == ST_VALID && qty_q > unit_max(term_unit))
			res_d.status = ST_RANGE;
		res_d.unit = term_unit;
		res_d.qty  = term_neg ? (32'd0 - qty_q) : qty_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			char_s1 <= char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			qty_q     <= '0;
			cnt_q     <= '0;
			unit_q    <= '0;
			neg_q     <= 1'b0;
			lit_pos_q <= '0;
		end else if (take_s1) begin
			phase_q   <= phase_d;
			qty_q     <= qty_d;
			cnt_q     <= cnt_d;
			unit_q    <= unit_d;
			neg_q     <= neg_d;
			lit_pos_q <= lit_pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && buf_we)
			buf_q[cnt_q[IDX_W-1:0]] <= char_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (take_s1 && char_s1 == CH_NUL) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && char_s1 == CH_NUL)
			res_s2 <= res_d;
	end

endmodule

### hdl/rttp_scale.sv
`timescale 1ns / 1ps
// scaling by seconds per unit, fallback value register and output register
module rttp_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic signed [31:0]  cfg_wr_data,
	input  logic                res_valid,
	input  rttp_pkg::rttp_res_t res,
	output logic                res_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          parse_status,
	output logic signed [31:0]  seconds,
	output logic [2:0]          unit_kind
);
	import rttp_pkg::*;

	logic signed [31:0] invalid_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic signed [31:0] seconds_q;
	logic [2:0]         unit_q;
	logic [31:0]        prod;
	logic               load;

	// quantity already carries its sign, so the low word of the product is final
	assign prod      = res.qty * unit_secs(res.unit);
	assign res_ready = !out_valid_q || out_ready;
	assign load      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invalid_q <= 32'sd2147483646;
		end else if (cfg_wr_en) begin
			invalid_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= res.status;
			if (res.status == ST_VALID) begin
				seconds_q <= prod;
				unit_q    <= res.unit;
			end else begin
				seconds_q <= invalid_q;
				unit_q    <= 3'd0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign parse_status = status_q;
	assign seconds      = seconds_q;
	assign unit_kind    = unit_q;

endmodule

### hdl/relative_time_text_parser.sv
`timescale 1ns / 1ps
// top level of the relative time text parser
// usage:
//   characters enter on char_code with in_valid / in_ready, one item per cycle while ready.
//   a zero character ends the string and produces one result on the output
//   channel (parse_status, seconds, unit_kind with out_valid / out_ready);
//   other characters produce nothing.
//   cfg_wr_en / cfg_wr_data load the seconds value given with every status
//   other than valid; write it only while the parser is idle.
// timing:
//   throughput is one character per cycle while in_ready is high. a result
//   passes from the input register through the parser into its result
//   register, then through the multiply into the output register.
// reset:
//   arst_n clears the parser to the waiting-for-first-non-blank state, empties the
//   input, result and output registers and sets the fallback to 2147483646.
// stall:
//   a held result keeps its value; characters that end no string keep flowing,
//   and one more finished string can wait in the parser's result register
//   before in_ready drops.
module relative_time_text_parser #(
	parameter int UNIT_LETTERS = rttp_pkg::UNIT_LETTERS_DEF,
	parameter int DIR_LETTERS  = rttp_pkg::DIR_LETTERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_code,
	input  logic               in_valid,
	output logic               in_ready,
	output logic [1:0]         parse_status,
	output logic signed [31:0] seconds,
	output logic [2:0]         unit_kind,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               cfg_wr_en,
	input  logic signed [31:0] cfg_wr_data
);
	import rttp_pkg::*;

	rttp_res_t res;
	logic      res_valid;
	logic      res_ready;

	rttp_parse #(
		.UNIT_LETTERS (UNIT_LETTERS),
		.DIR_LETTERS  (DIR_LETTERS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	rttp_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.parse_status (parse_status),
		.seconds      (seconds),
		.unit_kind    (unit_kind)
	);

endmodule

### hdl/rttp_check.sv
`timescale 1ns / 1ps
// port-level checks for the relative time text parser, bound to the top level
module rttp_check (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         parse_status,
	input logic signed [31:0] seconds,
	input logic [2:0]         unit_kind
);
	import rttp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(parse_status) &&
		$stable(seconds) && $stable(unit_kind))
		else $error("result changed while stalled");

	// failed parses never report a unit
	a_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_status != ST_VALID |-> unit_kind == 3'd0)
		else $error("unit reported with non-valid status");

	// minutes and longer units are multiples of four seconds, sign included
	a_minute_mult: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_status == ST_VALID && unit_kind != 3'd0 |->
		seconds[1:0] == 2'b00)
		else $error("minute-based value not a multiple of 60");

	// days and longer are multiples of 128 seconds
	a_day_mult: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_status == ST_VALID &&
		(unit_kind == 3'd3 || unit_kind == 3'd4 || unit_kind == 3'd5 ||
		 unit_kind == 3'd6) |-> seconds[6:0] == 7'd0)
		else $error("day-based value not a multiple of 86400");

endmodule

bind relative_time_text_parser rttp_check u_rttp_check (.*);
